>>> hdl/ssir_pkg.sv
// ----------------------------------------------------------------------------
// Sorted set package
// Shared types and constants for the sorted set insert/remove core and its
// chain of storage cells.
// ----------------------------------------------------------------------------
package ssir_pkg;

   localparam int CAPACITY_DEF = 16;

   // Operation codes carried in the request beat.
   localparam logic OP_INSERT = 1'b0;
   localparam logic OP_REMOVE = 1'b1;

   // Status codes carried in the response beat.
   localparam logic [1:0] ST_DONE = 2'd0;
   localparam logic [1:0] ST_MISS = 2'd1;
   localparam logic [1:0] ST_FULL = 2'd2;

   typedef struct packed {
      logic               operation;
      logic signed [31:0] value;
   } req_type;

   typedef struct packed {
      logic [1:0] status;
      logic [4:0] entry_count;
   } rsp_type;

   // Commands broadcast from the sequencer to every cell.
   typedef struct packed {
      logic cmp_en;
      logic do_insert;
      logic do_remove;
   } cell_ctrl_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_SEARCH,
      S_UPDATE
   } state_type;

endpackage

>>> hdl/sorted_set_insert_remove_core.sv
// ----------------------------------------------------------------------------
// Sorted set insert/remove core
// Keeps up to CAPACITY distinct signed 32-bit values in ascending order in a
// chain of cells and applies one insert or remove per request beat.
// ----------------------------------------------------------------------------
// Usage:
// A request beat carries an operation (insert or remove) and a signed value.
// It is taken when req_valid is high and req_stall is low. Every request
// produces exactly one response beat with a status (done, duplicate/absent,
// or full) and the number of entries held after the operation.
// Each request passes through an accept state, a search state in which
// every cell compares its entry with the value in parallel and registers the
// result, and an update state in which the cells shift toward or away from
// the insertion point in one step. The response is visible in the cycle after
// the update; a new request is taken only once the sequencer is back in idle,
// so requests do not overlap. The sequencer sets this pace; the cells
// themselves work in parallel regardless of CAPACITY.
// The response sits in an output register. While the receiver stalls, the
// core still accepts and searches the next request, and holds in the update
// cycle until the output register is free, so no response is lost.
// Reset empties the set at once; cell contents are not cleared, since only
// cells below the entry count are ever compared.
// ----------------------------------------------------------------------------
module sorted_set_insert_remove_core
   import ssir_pkg::*;
#(
   parameter int CAPACITY = CAPACITY_DEF
)
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_payload,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_payload
);

   // Count has to hold the value CAPACITY itself.
   localparam int CW = $clog2(CAPACITY + 1);

   state_type          state_ff;
   state_type          state_in;
   logic               op_ff;
   logic signed [31:0] key_ff;
   logic [CW-1:0]      count_ff;
   logic [CW-1:0]      count_in;
   logic               rsp_valid_ff;
   logic               rsp_valid_in;
   rsp_type            rsp_ff;
   rsp_type            rsp_in;

   cell_ctrl_type      ctrl;
   logic signed [31:0] entry_vec [CAPACITY];
   logic [CAPACITY-1:0] lt_vec;
   logic [CAPACITY-1:0] eq_vec;

   logic               found;
   logic               full;
   logic               out_free;
   logic [CW+4:0]      count_wide;

   // ------------------------------------------------------------------
   // Chain of cells. Each cell sees its neighbors' entries and the
   // comparison flag of the cell below it, which marks the insertion point.
   // ------------------------------------------------------------------
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      localparam logic [CW-1:0] SLOT = CW'(i);
      logic               left_lt;
      logic signed [31:0] left_entry;
      logic signed [31:0] right_entry;

      if (i == 0) begin : g_first
         assign left_lt    = 1'b1;
         assign left_entry = key_ff;
      end else begin : g_inner
         assign left_lt    = lt_vec[i-1];
         assign left_entry = entry_vec[i-1];
      end

      if (i == CAPACITY - 1) begin : g_last
         assign right_entry = entry_vec[i];
      end else begin : g_mid
         assign right_entry = entry_vec[i+1];
      end

      ssir_cell u_cell (
         .clock       (clock),
         .ctrl        (ctrl),
         .key         (key_ff),
         .occupied    (SLOT < count_ff),
         .left_lt     (left_lt),
         .left_entry  (left_entry),
         .right_entry (right_entry),
         .entry       (entry_vec[i]),
         .lt_flag     (lt_vec[i]),
         .eq_flag     (eq_vec[i])
      );
   end

   // The set holds no repeats, so at most one cell reports a match.
   assign found    = |eq_vec;
   assign full     = (count_ff == CW'(CAPACITY));
   assign out_free = !rsp_valid_ff || !rsp_stall;

   // ------------------------------------------------------------------
   // Sequencer: accept, search, update.
   // ------------------------------------------------------------------
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      ctrl         = '0;
      req_stall    = 1'b1;
      count_wide   = '0;

      unique case (state_ff)
         S_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               state_in = S_SEARCH;
            end
         end
         S_SEARCH: begin
            ctrl.cmp_en = 1'b1;
            state_in    = S_UPDATE;
         end
         S_UPDATE: begin
            if (out_free) begin
               if (op_ff == OP_INSERT) begin
                  if (found) begin
                     rsp_in.status = ST_MISS;
                  end else if (full) begin
                     rsp_in.status = ST_FULL;
                  end else begin
                     rsp_in.status  = ST_DONE;
                     ctrl.do_insert = 1'b1;
                     count_in       = count_ff + CW'(1);
                  end
               end else begin
                  if (found) begin
                     rsp_in.status  = ST_DONE;
                     ctrl.do_remove = 1'b1;
                     count_in       = count_ff - CW'(1);
                  end else begin
                     rsp_in.status = ST_MISS;
                  end
               end
               count_wide         = (CW+5)'(count_in);
               rsp_in.entry_count = count_wide[4:0];
               rsp_valid_in       = 1'b1;
               state_in           = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers need no reset.
   always_ff @(posedge clock) begin
      if (state_ff == S_IDLE && req_valid) begin
         op_ff  <= req_payload.operation;
         key_ff <= req_payload.value;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

>>> hdl/ssir_cell.sv
// ----------------------------------------------------------------------------
// Sorted set storage cell
// Holds one entry, compares it with the search key and shifts to or from its
// neighbors when an insert or remove is applied.
// ----------------------------------------------------------------------------
module ssir_cell
   import ssir_pkg::*;
(
   input  logic               clock,
   input  cell_ctrl_type      ctrl,
   input  logic signed [31:0] key,
   input  logic               occupied,
   input  logic               left_lt,
   input  logic signed [31:0] left_entry,
   input  logic signed [31:0] right_entry,
   output logic signed [31:0] entry,
   output logic               lt_flag,
   output logic               eq_flag
);

   logic signed [31:0] entry_ff;
   logic               lt_ff;
   logic               eq_ff;

   always_ff @(posedge clock) begin
      if (ctrl.cmp_en) begin
         lt_ff <= occupied && (entry_ff < key);
         eq_ff <= occupied && (entry_ff == key);
      end
      // Cells below the insertion point keep their entry; the cell at the
      // insertion point takes the key and the ones above it move up by one.
      if (ctrl.do_insert && !lt_ff) begin
         entry_ff <= left_lt ? key : left_entry;
      end else if (ctrl.do_remove && !lt_ff) begin
         entry_ff <= right_entry;
      end
   end

   assign entry   = entry_ff;
   assign lt_flag = lt_ff;
   assign eq_flag = eq_ff;

endmodule

>>> hdl/ssir_checker.sv
// ----------------------------------------------------------------------------
// Sorted set port checker
// Watches the ports of the sorted set core and flags behavior over time that
// the design must never show.
// ----------------------------------------------------------------------------
module ssir_checker
   import ssir_pkg::*;
#(
   parameter int CAPACITY = CAPACITY_DEF
)
(
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_stall,
   input logic    rsp_valid,
   input logic    rsp_stall,
   input rsp_type rsp_payload
);

   localparam logic [4:0] CAP_LOW = 5'(CAPACITY);

   // A stalled response beat stays and keeps its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_payload))
      else $error("response beat changed while stalled");

   // The core is busy in the cycle after it takes a request.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request taken while previous one in flight");

   // With the output register empty, the response follows the search and update states.
   a_latency: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && !rsp_valid |-> ##3 rsp_valid)
      else $error("response missing three cycles after request");

   // A full status only comes with a full table.
   a_full_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.status == ST_FULL |-> rsp_payload.entry_count == CAP_LOW)
      else $error("full status with table not full");

endmodule

bind sorted_set_insert_remove_core ssir_checker #(.CAPACITY(CAPACITY)) u_ssir_checker (.*);
